### sv/smcd_pkg.sv
// smcd_pkg: types, codes and result tables shared by the stylus multi-click detector
// no dependencies; imported by smcd_decide, smcd_emit and the top level
`timescale 1ns / 1ps

package smcd_pkg;

	localparam int TimeW    = 48;
	localparam int TimeoutW = 24;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = TimeoutW;
	localparam int SeqIdxW  = 3;

	localparam logic [TimeoutW-1:0] TimeoutReset = 24'd200000;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_CLICK_TOGGLE = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_US   = 1'd1;

	// input event kinds
	localparam logic [1:0] CMD_BUTTON = 2'd0;
	localparam logic [1:0] CMD_SYNC   = 2'd1;
	localparam logic [1:0] CMD_PROX   = 2'd2;

	// input values
	localparam logic [1:0] VAL_RELEASE = 2'd0;
	localparam logic [1:0] VAL_PRESS   = 2'd1;

	// result targets
	localparam logic TGT_PEN = 1'b0;
	localparam logic TGT_KBD = 1'b1;

	// result event codes
	localparam logic [2:0] EV_ERASER  = 3'd0;
	localparam logic [2:0] EV_PENTOOL = 3'd1;
	localparam logic [2:0] EV_LCTRL   = 3'd2;
	localparam logic [2:0] EV_KEYY    = 3'd3;
	localparam logic [2:0] EV_KEYZ    = 3'd4;
	localparam logic [2:0] EV_SYNC    = 3'd5;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [1:0]       value;
		logic [TimeW-1:0] time_us;
	} in_word_t;

	typedef struct packed {
		logic       target;
		logic [2:0] event_code;
		logic [1:0] event_value;
		logic       last;
	} out_word_t;

	// kinds of result runs
	typedef enum logic [1:0] {
		RUN_MIRROR    = 2'd0,
		RUN_PEN_CYCLE = 2'd1,
		RUN_UNDO      = 2'd2,
		RUN_REDO      = 2'd3
	} run_kind_t;

	// one pending run handed from the decision stage to the emitter
	typedef struct packed {
		run_kind_t  kind;
		logic [1:0] value;
	} run_t;

	function automatic logic [SeqIdxW-1:0] run_last_idx(input run_kind_t kind);
		logic [SeqIdxW-1:0] r;
		unique case (kind)
			RUN_MIRROR:    r = 3'd0;
			RUN_PEN_CYCLE: r = 3'd2;
			RUN_UNDO:      r = 3'd7;
			RUN_REDO:      r = 3'd7;
			default:       r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic out_word_t run_word(input run_t run, input logic [SeqIdxW-1:0] idx);
		out_word_t w;
		logic [2:0] key;
		key = (run.kind == RUN_REDO) ? EV_KEYY : EV_KEYZ;
		w.last = (idx == run_last_idx(run.kind));
		unique case (run.kind)
			RUN_MIRROR: begin
				w.target      = TGT_PEN;
				w.event_code  = EV_ERASER;
				w.event_value = run.value;
			end
			RUN_PEN_CYCLE: begin
				w.target = TGT_PEN;
				unique case (idx)
					3'd0: begin
						w.event_code  = EV_ERASER;
						w.event_value = 2'd0;
					end
					3'd1: begin
						w.event_code  = EV_PENTOOL;
						w.event_value = 2'd0;
					end
					default: begin
						w.event_code  = EV_PENTOOL;
						w.event_value = 2'd1;
					end
				endcase
			end
			default: begin
				// ctrl down, key down, key up, ctrl up, each followed by a sync
				w.target = TGT_KBD;
				if (idx[0]) begin
					w.event_code  = EV_SYNC;
					w.event_value = 2'd0;
				end else begin
					unique case (idx[2:1])
						2'd0: begin
							w.event_code  = EV_LCTRL;
							w.event_value = 2'd1;
						end
						2'd1: begin
							w.event_code  = key;
							w.event_value = 2'd1;
						end
						2'd2: begin
							w.event_code  = key;
							w.event_value = 2'd0;
						end
						default: begin
							w.event_code  = EV_LCTRL;
							w.event_value = 2'd0;
						end
					endcase
				end
			end
		endcase
		return w;
	endfunction

endpackage

### sv/smcd_decide.sv
// smcd_decide: input register, click state and the decision on each input word
// depends on smcd_pkg; hands result runs to smcd_emit
`timescale 1ns / 1ps

module smcd_decide import smcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                click_toggle,
	input  logic [TimeoutW-1:0] timeout_us,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_word,
	input  logic                slot_free,
	output logic                run_valid,
	output run_t                run
);

	logic             valid_s1;
	in_word_t         word_s1;
	logic [1:0]       click_count_q;
	logic             primed_q;
	logic [TimeW-1:0] last_click_time_q;
	logic             erasing_q;

	logic [1:0]       click_count_d;
	logic             primed_d;
	logic [TimeW-1:0] last_click_time_d;
	logic             erasing_d;
	logic [TimeW-1:0] gap;
	logic             later;
	logic             advance;

	assign gap   = word_s1.time_us - last_click_time_q;
	assign later = !gap[TimeW-1] && (gap[TimeW-2:0] > {{(TimeW-1-TimeoutW){1'b0}}, timeout_us});

	always_comb begin
		click_count_d     = click_count_q;
		primed_d          = primed_q;
		last_click_time_d = last_click_time_q;
		erasing_d         = erasing_q;
		run_valid         = 1'b0;
		run.kind          = RUN_MIRROR;
		run.value         = word_s1.value;
		if (valid_s1) begin
			if (word_s1.cmd == CMD_BUTTON) begin
				run_valid = !click_toggle;
				if (word_s1.value == VAL_PRESS) begin
					if (click_count_q != 2'd0 && later) begin
						click_count_d = 2'd1;
					end else if (click_count_q != 2'd3) begin
						click_count_d = click_count_q + 2'd1;
					end
					last_click_time_d = word_s1.time_us;
					primed_d          = 1'b0;
				end else if (word_s1.value == VAL_RELEASE) begin
					if (!later) begin
						primed_d          = 1'b1;
						last_click_time_d = word_s1.time_us;
					end else begin
						click_count_d = 2'd0;
						primed_d      = 1'b0;
					end
				end
			end else if (word_s1.cmd == CMD_SYNC && primed_q && later) begin
				if (click_count_q == 2'd1 && click_toggle) begin
					erasing_d = !erasing_q;
					run_valid = 1'b1;
					if (erasing_q) begin
						run.kind = RUN_PEN_CYCLE;
					end else begin
						run.value = 2'd1;
					end
				end else if (click_count_q[1]) begin
					run_valid = 1'b1;
					run.kind  = (click_count_q == 2'd3) ? RUN_REDO : RUN_UNDO;
				end
				click_count_d = 2'd0;
				primed_d      = 1'b0;
			end else if (word_s1.cmd == CMD_PROX && erasing_q) begin
				run_valid = 1'b1;
			end
		end
	end

	// a word with no results leaves at once; one with results waits for the emitter
	assign advance  = valid_s1 && (!run_valid || slot_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			click_count_q     <= 2'd0;
			primed_q          <= 1'b0;
			last_click_time_q <= '0;
			erasing_q         <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				click_count_q     <= click_count_d;
				primed_q          <= primed_d;
				last_click_time_q <= last_click_time_d;
				erasing_q         <= erasing_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

### sv/smcd_emit.sv
// smcd_emit: run register and sequencer that sends one result word per cycle while out_ready is high
// depends on smcd_pkg; fed by smcd_decide
`timescale 1ns / 1ps

module smcd_emit import smcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run_valid,
	input  run_t      run,
	output logic      slot_free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic               busy_q;
	run_t               run_q;
	logic [SeqIdxW-1:0] idx_q;
	logic               fire;
	logic               load;

	assign out_valid = busy_q;
	assign out_word  = run_word(run_q, idx_q);
	assign fire      = busy_q && out_ready;
	assign slot_free = !busy_q || (fire && out_word.last);
	assign load      = run_valid && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (fire) begin
				if (out_word.last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= run_last_idx(run_q.kind))
		else $error("result index past end of run");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !out_word.last |=> busy_q && idx_q == $past(idx_q) + 1'b1)
		else $error("run did not step to next word");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == '0)
		else $error("new run did not start at first word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_ready |=> busy_q && $stable(idx_q))
		else $error("stalled run moved");
`endif

endmodule

### sv/stylus_multi_click_detector_core.sv
// stylus_multi_click_detector_core: top level of the stylus multi-click detector
// depends on smcd_pkg, smcd_decide and smcd_emit
`timescale 1ns / 1ps

//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+---------------------------------
//  input   | in_valid, in_ready, in_word      | in        | cmd, value, time_us
//  output  | out_valid, out_ready, out_word   | out       | target, event_code, event_value, last
//  config  | cfg_we, cfg_idx, cfg_data        | in        | 0 click toggle, 1 timeout_us
//
// an input word is held in the decision register; the 48-bit gap compare and
// the click state update happen there, so a word with no results leaves the next cycle
// results go out one per cycle from the emitter while out_ready is high, in result runs
// of 1, 3 or 8 words per result-bearing input word; the emitter run length sets the sustained rate
// the decision register takes a new word while the emitter still drains a run; a word
// with results waits there until the current run's last word is taken
// reset (arst_n low) clears click state, eraser state, the config registers and all valid flags

module stylus_multi_click_detector_core import smcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output out_word_t           out_word
);

	logic                click_toggle_q;
	logic [TimeoutW-1:0] timeout_us_q;
	logic                slot_free;
	logic                run_valid;
	run_t                run;

	// configuration registers: the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_toggle_q <= 1'b0;
			timeout_us_q   <= TimeoutReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CLICK_TOGGLE: click_toggle_q <= cfg_data[0];
				CFG_TIMEOUT_US:   timeout_us_q   <= cfg_data[TimeoutW-1:0];
				default:          ;
			endcase
		end
	end

	// decision stage: click counting, timeout check, eraser state
	smcd_decide u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.click_toggle (click_toggle_q),
		.timeout_us   (timeout_us_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_word      (in_word),
		.slot_free    (slot_free),
		.run_valid    (run_valid),
		.run          (run)
	);

	// result sequencer: mirror, pen re-proximity or undo/redo key runs
	smcd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run       (run),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_word.last && !run_valid |=> !out_valid)
		else $error("output stayed valid after last word with nothing queued");

	a_kbd_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.target == TGT_KBD && out_word.last |->
			out_word.event_code == EV_SYNC)
		else $error("key run did not end on a sync");

	a_pen_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.target == TGT_PEN |->
			out_word.event_code == EV_ERASER || out_word.event_code == EV_PENTOOL)
		else $error("pen result with keyboard code");
`endif

endmodule

### tb/tb.sv
// tb: self-checking testbench for stylus_multi_click_detector_core
// holds a click/eraser predictor in a small scoreboard class; depends on smcd_pkg and the core
`timescale 1ns / 1ps

module tb;
	import smcd_pkg::*;

	// event kinds and values the package leaves unnamed
	localparam logic [1:0] CMD_OTHER   = 2'd3;
	localparam logic [1:0] VAL_REPEAT  = 2'd2;
	localparam logic [1:0] VAL_UNKNOWN = 2'd3;

	localparam logic [TimeoutW-1:0] TimeoutMax = 24'hFF_FFFF;

	localparam int DrainCycles = 8;    // decision register plus emitter slack
	localparam int TailCycles  = 16;
	localparam int StuckLimit  = 3000; // cycles with no word moving on either channel
	localparam int RandPhases  = 8;
	localparam int PhaseWords  = 12;

	// predictor of the click decision logic plus the queue of result words still owed
	class click_scoreboard;
		bit                  click_toggle;
		logic [TimeoutW-1:0] timeout_us;
		logic [1:0]          clicks;
		bit                  primed;
		logic [TimeW-1:0]    last_edge_us;
		bit                  erasing;
		out_word_t           run_q[$];
		out_word_t           expected_q[$];
		int                  errors;
		int                  words_in;
		int                  words_out;
		int                  key_seqs;
		int                  eraser_flips;

		function new();
			click_toggle = 1'b0;
			timeout_us   = TimeoutReset;
			clicks       = '0;
			primed       = 1'b0;
			last_edge_us = '0;
			erasing      = 1'b0;
			errors       = 0;
			words_in     = 0;
			words_out    = 0;
			key_seqs     = 0;
			eraser_flips = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			if (idx == CFG_CLICK_TOGGLE)
				click_toggle = data[0];
			else
				timeout_us = data;
		endfunction

		// wraparound gap since the last click edge, negative gaps never count as late
		function bit past_timeout(logic [TimeW-1:0] stamp);
			logic [TimeW-1:0] gap;
			gap = stamp - last_edge_us;
			return !gap[TimeW-1] && (gap > TimeW'(timeout_us));
		endfunction

		function void add(logic tgt, logic [2:0] code, logic [1:0] value);
			out_word_t w;
			w.target      = tgt;
			w.event_code  = code;
			w.event_value = value;
			w.last        = 1'b0;
			run_q.push_back(w);
		endfunction

		function void note_input(in_word_t w);
			logic [2:0] key;
			out_word_t  tail;
			run_q.delete();
			words_in++;
			if (w.cmd == CMD_BUTTON) begin
				if (!click_toggle)
					add(TGT_PEN, EV_ERASER, w.value);
				if (w.value == VAL_PRESS) begin
					if (clicks != 2'd0 && past_timeout(w.time_us))
						clicks = 2'd0;
					if (clicks != 2'd3)
						clicks++;
					last_edge_us = w.time_us;
					primed       = 1'b0;
				end else if (w.value == VAL_RELEASE) begin
					if (!past_timeout(w.time_us)) begin
						primed       = 1'b1;
						last_edge_us = w.time_us;
					end else begin
						clicks = 2'd0;
						primed = 1'b0;
					end
				end
			end else if (w.cmd == CMD_SYNC && primed && past_timeout(w.time_us)) begin
				if (clicks == 2'd1 && click_toggle) begin
					erasing = !erasing;
					eraser_flips++;
					add(TGT_PEN, EV_ERASER, {1'b0, erasing});
					if (!erasing) begin
						add(TGT_PEN, EV_PENTOOL, 2'd0);
						add(TGT_PEN, EV_PENTOOL, 2'd1);
					end
				end else if (clicks > 2'd1) begin
					key_seqs++;
					key = (clicks == 2'd3) ? EV_KEYY : EV_KEYZ;
					add(TGT_KBD, EV_LCTRL, 2'd1);
					add(TGT_KBD, EV_SYNC, 2'd0);
					add(TGT_KBD, key, 2'd1);
					add(TGT_KBD, EV_SYNC, 2'd0);
					add(TGT_KBD, key, 2'd0);
					add(TGT_KBD, EV_SYNC, 2'd0);
					add(TGT_KBD, EV_LCTRL, 2'd0);
					add(TGT_KBD, EV_SYNC, 2'd0);
				end
				clicks = 2'd0;
				primed = 1'b0;
			end else if (w.cmd == CMD_PROX && erasing) begin
				add(TGT_PEN, EV_ERASER, w.value);
			end
			if (run_q.size() > 0) begin
				tail      = run_q.pop_back();
				tail.last = 1'b1;
				run_q.push_back(tail);
			end
			foreach (run_q[i])
				expected_q.push_back(run_q[i]);
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			words_out++;
			if (expected_q.size() == 0) begin
				$error("result word %h arrived with nothing expected", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.target !== want.target) begin
				$error("target: expected %0d, got %0d", want.target, got.target);
				errors++;
			end
			if (got.event_code !== want.event_code) begin
				$error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
				errors++;
			end
			if (got.event_value !== want.event_value) begin
				$error("event_value: expected %0d, got %0d", want.event_value, got.event_value);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	// every input starts at a known value
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx   = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_word_t            in_word   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_word_t           out_word;

	click_scoreboard  sb;
	logic [TimeW-1:0] stamp_us;          // running pen clock, wraps like the real one
	int unsigned      send_idle_pct  = 0;
	int unsigned      recv_stall_pct = 0;
	int               words_sent     = 0;
	int               settings_seen  = 0;
	int               stuck_cycles   = 0;

	stylus_multi_click_detector_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: check what was taken at this edge, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_word);
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog: any long stretch with no word moving means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == StuckLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// offer one word at the current stamp; valid stays up until the block takes it
	task automatic send_word(input logic [1:0] cmd, input logic [1:0] value);
		in_word_t w;
		w.cmd     = cmd;
		w.value   = value;
		w.time_us = stamp_us;
		// sender gaps: valid drops only on cycles where no word is offered
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(w);
		words_sent++;
	endtask

	// stop offering, let every owed result out, then give wordless items time to retire
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// both registers are written back to back while the block sits idle
	task automatic set_config(input bit toggle, input logic [TimeoutW-1:0] timeout);
		settle();
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_CLICK_TOGGLE;
		cfg_data <= CfgDataW'(toggle);
		@(posedge clk);
		sb.write_reg(CFG_CLICK_TOGGLE, CfgDataW'(toggle));
		cfg_idx  <= CFG_TIMEOUT_US;
		cfg_data <= timeout;
		@(posedge clk);
		sb.write_reg(CFG_TIMEOUT_US, timeout);
		cfg_we <= 1'b0;
		settings_seen++;
	endtask

	// gap between click edges: mostly within the timeout, hitting zero and the
	// timeout itself; a noisy train sometimes waits too long and breaks the count
	function automatic logic [TimeW-1:0] pick_gap(input bit noisy);
		int unsigned r;
		int unsigned t;
		r = $urandom_range(0, 9);
		t = 32'(sb.timeout_us);
		if (noisy && r == 0)
			return TimeW'(t) + TimeW'($urandom_range(1, 1000));
		if (r == 1)
			return '0;
		if (r == 2)
			return TimeW'(t);
		return TimeW'($urandom_range(0, t));
	endfunction

	// n press/release pairs, then a sync late enough to act on the count;
	// noisy trains may also carry a sync that comes too soon
	task automatic click_train(input int n, input bit noisy);
		int k;
		for (k = 0; k < n; k++) begin
			stamp_us += pick_gap(noisy);
			send_word(CMD_BUTTON, VAL_PRESS);
			stamp_us += pick_gap(noisy);
			send_word(CMD_BUTTON, VAL_RELEASE);
		end
		if (noisy && $urandom_range(0, 5) == 0) begin
			stamp_us += pick_gap(1'b0);
			send_word(CMD_SYNC, 2'($urandom_range(0, 3)));
		end
		stamp_us += TimeW'(sb.timeout_us) + TimeW'($urandom_range(1, 40));
		send_word(CMD_SYNC, 2'($urandom_range(0, 3)));
	endtask

	// any kind and value, with the stamp moving forward, backward, jumping
	// anywhere, or half the wrap ahead so the gap reads negative
	task automatic noise_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			stamp_us += TimeW'($urandom_range(0, 2 * sb.timeout_us));
		else if (r < 8)
			stamp_us -= TimeW'($urandom_range(1, sb.timeout_us));
		else if (r == 8)
			stamp_us = {16'($urandom), $urandom};
		else
			stamp_us += 48'h8000_0000_0000;
		send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
	endtask

	initial begin
		bit                  toggle;
		logic [TimeoutW-1:0] timeout;
		int                  p;
		int                  goal;

		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, mirror mode at reset settings, no pacing gaps
		stamp_us = 48'd100;
		send_word(CMD_OTHER, VAL_PRESS);      // other events are ignored
		send_word(CMD_PROX, VAL_PRESS);       // proximity with eraser off: nothing
		send_word(CMD_BUTTON, VAL_REPEAT);    // repeat only mirrors
		send_word(CMD_BUTTON, VAL_UNKNOWN);   // unknown value only mirrors
		send_word(CMD_BUTTON, VAL_RELEASE);   // release with no press before it
		click_train(1, 1'b0);                 // single click outside toggle mode
		click_train(2, 1'b0);                 // ctrl+Z
		click_train(4, 1'b0);                 // count saturates, ctrl+Y

		// toggle mode, widest timeout, stamps wrapping through zero
		set_config(1'b1, TimeoutMax);
		stamp_us = 48'hFFFF_FFFF_FFF0;
		send_word(CMD_BUTTON, VAL_PRESS);
		stamp_us += 48'd10;
		send_word(CMD_BUTTON, VAL_RELEASE);
		stamp_us += TimeW'(TimeoutMax);
		send_word(CMD_SYNC, 2'd0);            // exactly the timeout is not late
		stamp_us += 48'd1;
		send_word(CMD_SYNC, 2'd3);            // one past: eraser turns on
		send_word(CMD_PROX, VAL_PRESS);       // proximity mirrored while eraser on

		// leaving toggle mode keeps the eraser on
		set_config(1'b0, 24'd1);
		stamp_us += 48'd1;
		send_word(CMD_PROX, VAL_RELEASE);

		// shortest timeout: eraser off re-sends pen tool away then near
		set_config(1'b1, 24'd1);
		click_train(1, 1'b0);

		// random phases: mostly click trains with random timing, the rest noise;
		// pacing rotates through none, sender gaps, receiver stalls, both
		for (p = 0; p < RandPhases; p++) begin
			toggle = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
			case (p)
				0: begin
					timeout = 24'd1;
				end
				1: begin
					timeout = TimeoutMax;
				end
				2: begin
					timeout = TimeoutReset;
				end
				default: begin
					if ($urandom_range(0, 1))
						timeout = TimeoutW'($urandom_range(1, 2000));
					else
						timeout = TimeoutW'($urandom_range(1, TimeoutMax));
				end
			endcase
			set_config(toggle, timeout);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct  = 35;
					recv_stall_pct = 35;
				end
			endcase
			// fresh random base so every stamp bit moves
			stamp_us = {16'($urandom), $urandom};
			goal     = words_sent + PhaseWords;
			while (words_sent < goal) begin
				if ($urandom_range(0, 9) < 7)
					click_train($urandom_range(1, 4), 1'b1);
				else
					noise_word();
			end
		end

		settle();
		repeat (TailCycles) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d result words never arrived", sb.expected_q.size());
			sb.errors++;
		end

		$display("run: %0d pen events in, %0d result words checked, %0d register settings",
			sb.words_in, sb.words_out, settings_seen);
		$display("run: %0d undo/redo key sequences, %0d eraser flips, four pacing modes",
			sb.key_seqs, sb.eraser_flips);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### stylus_multi_click_detector_core.f
sv/smcd_pkg.sv
sv/smcd_decide.sv
sv/smcd_emit.sv
sv/stylus_multi_click_detector_core.sv
tb/tb.sv
